>>> rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache and responder: opcodes,
// register indexes, header check values and the token that walks the cells.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAC_W             = 48;
    localparam int IP_W              = 32;
    localparam int CFG_W             = 48;

    // item opcodes
    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_RESOLVE = 2'd2;

    // configuration register indexes
    localparam logic REG_OUR_MAC = 1'b0;
    localparam logic REG_OUR_IP  = 1'b1;

    // ARP header checks
    localparam logic [10:0] MIN_ARP_LEN    = 11'd28;
    localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [15:0] OPER_REQUEST   = 16'h0001;

    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_LEARN,
        TOK_LOOKUP
    } arpc_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } arpc_state_t;

    // token handed from cell to cell; mac carries the learned address on the
    // way in and the found address on the way out of a lookup
    typedef struct packed {
        logic              valid;
        arpc_kind_t        kind;
        logic              found;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
    } arpc_tok_t;

endpackage

>>> rtl/core/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell
// One table entry. Checks the passing token against its entry, learns or
// answers, and registers the token on to the next cell.
// ----------------------------------------------------------------------------
module arpc_cell
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  arpc_tok_t tok_in,
    output arpc_tok_t tok_out
);

    logic             valid_reg, valid_next;
    logic [IP_W-1:0]  ip_reg, ip_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    arpc_tok_t        tok_reg, tok_next;
    logic             tok_vld_reg;
    logic             match;

    always_comb
    begin
        match      = valid_reg && (ip_reg == tok_in.ip);
        valid_next = valid_reg;
        ip_next    = ip_reg;
        mac_next   = mac_reg;
        tok_next   = tok_in;
        if (tok_in.valid && !tok_in.found)
        begin
            unique case (tok_in.kind)
                TOK_LEARN:
                begin
                    if (match)
                    begin
                        mac_next       = tok_in.mac;
                        tok_next.found = 1'b1;
                    end
                    else if (!valid_reg)
                    begin
                        // valid entries form a prefix, so this is the lowest free slot
                        valid_next     = 1'b1;
                        ip_next        = tok_in.ip;
                        mac_next       = tok_in.mac;
                        tok_next.found = 1'b1;
                    end
                end
                TOK_LOOKUP:
                begin
                    if (match)
                    begin
                        tok_next.found = 1'b1;
                        tok_next.mac   = mac_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            tok_vld_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg  <= ip_next;
        mac_reg <= mac_next;
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_vld_reg;
    end

endmodule

>>> rtl/core/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Command sequencer: checks the item, launches a token into the cell chain,
// waits for it at the tail and forms the result.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    input  logic [1:0]       opcode,
    input  logic [10:0]      packet_len,
    input  logic [15:0]      hw_type,
    input  logic [15:0]      proto_type,
    input  logic [15:0]      operation,
    input  logic [MAC_W-1:0] sender_mac,
    input  logic [IP_W-1:0]  sender_ip,
    input  logic [IP_W-1:0]  tgt_ip,
    input  logic [IP_W-1:0]  query_ip,
    input  logic [IP_W-1:0]  our_ip,
    output arpc_tok_t        head,
    input  arpc_tok_t        tail,
    output logic             accepted,
    output logic             reply_valid,
    output logic [MAC_W-1:0] reply_dest_mac,
    output logic [IP_W-1:0]  reply_target_ip,
    output logic             hit,
    output logic [MAC_W-1:0] found_mac,
    output logic             request_valid,
    output logic [IP_W-1:0]  request_target_ip
);

    arpc_state_t      state_reg, state_next;
    arpc_tok_t        head_reg, head_next;
    logic             head_vld_reg;
    logic             take;
    logic             pkt_ok;

    // item held while the token sweeps
    logic             acc_reg, acc_next;
    logic             rep_reg, rep_next;
    logic             res_reg, res_next;
    logic [MAC_W-1:0] smac_reg;
    logic [IP_W-1:0]  sip_reg;
    logic [IP_W-1:0]  qip_reg;

    // result
    logic             done_reg, done_next;
    logic             accepted_reg, accepted_next;
    logic             reply_valid_reg, reply_valid_next;
    logic [MAC_W-1:0] reply_dest_mac_reg, reply_dest_mac_next;
    logic [IP_W-1:0]  reply_target_ip_reg, reply_target_ip_next;
    logic             hit_reg, hit_next;
    logic [MAC_W-1:0] found_mac_reg, found_mac_next;
    logic             request_valid_reg, request_valid_next;
    logic [IP_W-1:0]  request_target_ip_reg, request_target_ip_next;

    always_comb
    begin
        take   = start && (state_reg == ST_IDLE);
        pkt_ok = (packet_len >= MIN_ARP_LEN) && (hw_type == HTYPE_ETHERNET)
                 && (proto_type == PTYPE_IPV4);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SWEEP;
            ST_SWEEP: if (tail.valid) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase

        head_next       = head_reg;
        head_next.valid = take;
        acc_next        = acc_reg;
        rep_next        = rep_reg;
        res_next        = res_reg;
        if (take)
        begin
            head_next.found = 1'b0;
            head_next.mac   = sender_mac;
            head_next.ip    = query_ip;
            head_next.kind  = TOK_NONE;
            acc_next        = 1'b0;
            rep_next        = 1'b0;
            res_next        = 1'b0;
            unique case (opcode)
                OP_RX:
                begin
                    head_next.ip = sender_ip;
                    if (pkt_ok)
                    begin
                        head_next.kind = TOK_LEARN;
                        acc_next       = 1'b1;
                        rep_next       = (operation == OPER_REQUEST) && (tgt_ip == our_ip);
                    end
                end
                OP_LOOKUP:  head_next.kind = TOK_LOOKUP;
                OP_RESOLVE:
                begin
                    head_next.kind = TOK_LOOKUP;
                    res_next       = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        done_next              = tail.valid && (state_reg == ST_SWEEP);
        accepted_next          = acc_reg;
        reply_valid_next       = rep_reg;
        reply_dest_mac_next    = rep_reg ? smac_reg : '0;
        reply_target_ip_next   = rep_reg ? sip_reg : '0;
        hit_next               = tail.found && (tail.kind == TOK_LOOKUP);
        found_mac_next         = hit_next ? tail.mac : '0;
        request_valid_next     = res_reg && !tail.found;
        request_target_ip_next = request_valid_next ? qip_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_vld_reg <= head_next.valid;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        acc_reg  <= acc_next;
        rep_reg  <= rep_next;
        res_reg  <= res_next;
        if (take)
        begin
            smac_reg <= sender_mac;
            sip_reg  <= sender_ip;
            qip_reg  <= query_ip;
        end
        if (done_next)
        begin
            accepted_reg          <= accepted_next;
            reply_valid_reg       <= reply_valid_next;
            reply_dest_mac_reg    <= reply_dest_mac_next;
            reply_target_ip_reg   <= reply_target_ip_next;
            hit_reg               <= hit_next;
            found_mac_reg         <= found_mac_next;
            request_valid_reg     <= request_valid_next;
            request_target_ip_reg <= request_target_ip_next;
        end
    end

    always_comb
    begin
        head       = head_reg;
        head.valid = head_vld_reg;
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign accepted          = accepted_reg;
    assign reply_valid       = reply_valid_reg;
    assign reply_dest_mac    = reply_dest_mac_reg;
    assign reply_target_ip   = reply_target_ip_reg;
    assign hit               = hit_reg;
    assign found_mac         = found_mac_reg;
    assign request_valid     = request_valid_reg;
    assign request_target_ip = request_target_ip_reg;

endmodule

>>> rtl/core/arp_cache_and_responder.sv
// ----------------------------------------------------------------------------
// arp_cache_and_responder
// IPv4-to-MAC cache with ARP request responder, one entry per cell.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------
//  command   | opcode .. query_ip                      | start && !busy
//  result    | accepted .. request_target_ip           | done, one cycle, no stall
//  config    | cfg_we, cfg_addr, cfg_data              | cfg_we, no wait
//
//  The token walks the cell chain one cell per clock, one item in flight at a
//  time; busy stays high while it sweeps, and done follows its arrival at the
//  tail.
//  Reset clears all entry valid bits at once; no clearing pass is needed.
//  The result receiver cannot stall: done marks a one-cycle result, and the
//  result ports hold their value until the next done.
// ----------------------------------------------------------------------------
module arp_cache_and_responder
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       opcode,
    input  logic [10:0]      packet_len,
    input  logic [15:0]      hw_type,
    input  logic [15:0]      proto_type,
    input  logic [15:0]      operation,
    input  logic [MAC_W-1:0] sender_mac,
    input  logic [IP_W-1:0]  sender_ip,
    input  logic [IP_W-1:0]  tgt_ip,
    input  logic [IP_W-1:0]  query_ip,
    // configuration
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_data,
    // result
    output logic             done,
    output logic             accepted,
    output logic             reply_valid,
    output logic [MAC_W-1:0] reply_dest_mac,
    output logic [IP_W-1:0]  reply_target_ip,
    output logic             hit,
    output logic [MAC_W-1:0] found_mac,
    output logic             request_valid,
    output logic [IP_W-1:0]  request_target_ip
);

    // Only our_ip affects any result; the reply's sender MAC is filled in by
    // the frame builder, so writes to the our_mac index are taken and dropped.
    logic [IP_W-1:0] our_ip_reg, our_ip_next;

    always_comb
    begin
        our_ip_next = our_ip_reg;
        if (cfg_we && (cfg_addr == REG_OUR_IP))
        begin
            our_ip_next = cfg_data[IP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            our_ip_reg <= '0;
        end
        else
        begin
            our_ip_reg <= our_ip_next;
        end
    end

    // link[i] feeds cell i; link[TABLE_ENTRIES] is the tail back to control
    arpc_tok_t link [TABLE_ENTRIES+1];

    arpc_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .done              (done),
        .opcode            (opcode),
        .packet_len        (packet_len),
        .hw_type           (hw_type),
        .proto_type        (proto_type),
        .operation         (operation),
        .sender_mac        (sender_mac),
        .sender_ip         (sender_ip),
        .tgt_ip            (tgt_ip),
        .query_ip          (query_ip),
        .our_ip            (our_ip_reg),
        .head              (link[0]),
        .tail              (link[TABLE_ENTRIES]),
        .accepted          (accepted),
        .reply_valid       (reply_valid),
        .reply_dest_mac    (reply_dest_mac),
        .reply_target_ip   (reply_target_ip),
        .hit               (hit),
        .found_mac         (found_mac),
        .request_valid     (request_valid),
        .request_target_ip (request_target_ip)
    );

    // Entries fill from cell 0 upward and are never freed, so the first
    // free cell the token meets is the lowest free slot, and an IP sits in
    // at most one valid cell.
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        arpc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

endmodule

>>> rtl/core/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks on the ARP cache: command/result sequencing and result
// consistency.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic accepted,
    input logic reply_valid,
    input logic hit,
    input logic request_valid
);

    // a taken command always makes the block busy
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command taken but busy not raised");

    // a result comes out only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // results are single-cycle and never back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a hit never also asks for a request; a reply implies an accepted packet
    a_result_mix: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && request_valid) && (!reply_valid || accepted))
        else $error("inconsistent result fields");

endmodule

bind arp_cache_and_responder arpc_checker u_arpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .accepted      (accepted),
    .reply_valid   (reply_valid),
    .hit           (hit),
    .request_valid (request_valid)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb - ARP cache and responder testbench
// Drives receive, lookup and resolve items through the command port and keeps
// its own copy of the IPv4-to-MAC table and station IP. Each item is
// predicted when accepted, and each done strobe is checked field by field
// against the oldest outstanding prediction. Directed cases cover header
// rejection, learning, replies and queries. Random phases then run with
// several register settings and sender idling patterns.
// ----------------------------------------------------------------------------
module tb
    import arpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // unused opcode: the block answers with an all-zero result
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [15:0] OPER_REPLY  = 16'h0002;
    localparam int          POOL_SIZE   = 20;
    localparam int          PHASE_ITEMS = 150;
    localparam int          STALL_LIMIT = 3000;
    // start to done; the closing wait adds a margin to it
    localparam int          ITEM_CYCLES = TABLE_ENTRIES_DEF + 2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [10:0]      packet_len;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [15:0]      operation;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  tgt_ip;
        logic [IP_W-1:0]  query_ip;
    } arp_item_t;

    typedef struct packed {
        logic             accepted;
        logic             reply_valid;
        logic [MAC_W-1:0] reply_dest_mac;
        logic [IP_W-1:0]  reply_target_ip;
        logic             hit;
        logic [MAC_W-1:0] found_mac;
        logic             request_valid;
        logic [IP_W-1:0]  request_target_ip;
    } arp_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       opcode;
    logic [10:0]      packet_len;
    logic [15:0]      hw_type;
    logic [15:0]      proto_type;
    logic [15:0]      operation;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  tgt_ip;
    logic [IP_W-1:0]  query_ip;
    logic             cfg_we;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_data;
    logic             done;
    logic             accepted;
    logic             reply_valid;
    logic [MAC_W-1:0] reply_dest_mac;
    logic [IP_W-1:0]  reply_target_ip;
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             request_valid;
    logic [IP_W-1:0]  request_target_ip;

    // shadow of the cache table and station IP
    logic [TABLE_ENTRIES_DEF-1:0] cache_valid;
    logic [IP_W-1:0]              cache_ip  [TABLE_ENTRIES_DEF];
    logic [MAC_W-1:0]             cache_mac [TABLE_ENTRIES_DEF];
    logic [IP_W-1:0]              station_ip;

    arp_result_t expected_results[$];
    arp_result_t want;
    int          mismatches  = 0;
    int          stall_cycles;
    logic [IP_W-1:0] ip_pool [POOL_SIZE];

    arp_cache_and_responder i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .packet_len        (packet_len),
        .hw_type           (hw_type),
        .proto_type        (proto_type),
        .operation         (operation),
        .sender_mac        (sender_mac),
        .sender_ip         (sender_ip),
        .tgt_ip            (tgt_ip),
        .query_ip          (query_ip),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_data          (cfg_data),
        .done              (done),
        .accepted          (accepted),
        .reply_valid       (reply_valid),
        .reply_dest_mac    (reply_dest_mac),
        .reply_target_ip   (reply_target_ip),
        .hit               (hit),
        .found_mac         (found_mac),
        .request_valid     (request_valid),
        .request_target_ip (request_target_ip)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Cache predictor
    // ------------------------------------------------------------------------

    // lowest valid slot holding ip, or -1
    function automatic int find_slot(input logic [IP_W-1:0] ip);
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
        begin
            if (cache_valid[i] && cache_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    // Works out the result of one item and applies its effect on the table.
    function automatic arp_result_t predict_result(input arp_item_t it);
        arp_result_t r;
        int          slot;
        logic        placed;
        r = '0;
        case (it.opcode)
            OP_RX:
            begin
                if (it.packet_len >= MIN_ARP_LEN && it.hw_type == HTYPE_ETHERNET &&
                    it.proto_type == PTYPE_IPV4)
                begin
                    // learn: refresh a matching entry, else take the lowest free
                    // slot; a full table drops the pair but still accepts
                    slot = find_slot(it.sender_ip);
                    if (slot >= 0)
                        cache_mac[slot] = it.sender_mac;
                    else
                    begin
                        placed = 1'b0;
                        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
                        begin
                            if (!placed && !cache_valid[i])
                            begin
                                cache_valid[i] = 1'b1;
                                cache_ip[i]    = it.sender_ip;
                                cache_mac[i]   = it.sender_mac;
                                placed         = 1'b1;
                            end
                        end
                    end
                    r.accepted = 1'b1;
                    if (it.operation == OPER_REQUEST && it.tgt_ip == station_ip)
                    begin
                        r.reply_valid     = 1'b1;
                        r.reply_dest_mac  = it.sender_mac;
                        r.reply_target_ip = it.sender_ip;
                    end
                end
            end
            OP_LOOKUP, OP_RESOLVE:
            begin
                slot = find_slot(it.query_ip);
                if (slot >= 0)
                begin
                    r.hit       = 1'b1;
                    r.found_mac = cache_mac[slot];
                end
                else if (it.opcode == OP_RESOLVE)
                begin
                    r.request_valid     = 1'b1;
                    r.request_target_ip = it.query_ip;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: outputs sampled at the rising edge
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [MAC_W-1:0] exp_v,
                               input logic [MAC_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("accepted", MAC_W'(want.accepted), MAC_W'(accepted));
                check_field("reply_valid", MAC_W'(want.reply_valid), MAC_W'(reply_valid));
                check_field("reply_dest_mac", want.reply_dest_mac, reply_dest_mac);
                check_field("reply_target_ip", MAC_W'(want.reply_target_ip),
                            MAC_W'(reply_target_ip));
                check_field("hit", MAC_W'(want.hit), MAC_W'(hit));
                check_field("found_mac", want.found_mac, found_mac);
                check_field("request_valid", MAC_W'(want.request_valid),
                            MAC_W'(request_valid));
                check_field("request_target_ip", MAC_W'(want.request_target_ip),
                            MAC_W'(request_target_ip));
            end
        end
    end

    // Watchdog: counts cycles with neither an accepted item nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Drivers: everything changes on the falling edge
    // ------------------------------------------------------------------------

    // Presents one item and holds it until the block takes it. start is left
    // high so that a following item can go back to back; a gap or a drain
    // lowers it at the next falling edge.
    task automatic push_item(input arp_item_t it);
        @(negedge clk);
        start      <= 1'b1;
        opcode     <= it.opcode;
        packet_len <= it.packet_len;
        hw_type    <= it.hw_type;
        proto_type <= it.proto_type;
        operation  <= it.operation;
        sender_mac <= it.sender_mac;
        sender_ip  <= it.sender_ip;
        tgt_ip     <= it.tgt_ip;
        query_ip   <= it.query_ip;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_result(it));
    endtask

    // Sender idles for a random stretch with probability pct in a hundred.
    task automatic idle_gap(input int pct);
        int n;
        if ($urandom_range(99) < pct)
        begin
            n = $urandom_range(24, 1);
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Station registers are only written with the block idle.
    task automatic set_station(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip);
        drain_results();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_OUR_MAC;
        cfg_data <= mac;
        @(posedge clk);
        @(negedge clk);
        cfg_addr <= REG_OUR_IP;
        cfg_data <= CFG_W'(ip);
        @(posedge clk);
        station_ip = ip;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic arp_item_t rx_item(input logic [10:0] len, input logic [15:0] hw,
                                          input logic [15:0] proto, input logic [15:0] oper,
                                          input logic [MAC_W-1:0] smac,
                                          input logic [IP_W-1:0] sip,
                                          input logic [IP_W-1:0] tip);
        arp_item_t it;
        it.opcode     = OP_RX;
        it.packet_len = len;
        it.hw_type    = hw;
        it.proto_type = proto;
        it.operation  = oper;
        it.sender_mac = smac;
        it.sender_ip  = sip;
        it.tgt_ip     = tip;
        it.query_ip   = $urandom;
        return it;
    endfunction

    // Query items carry random packet fields, which the block must ignore.
    function automatic arp_item_t query_item(input logic [1:0] op,
                                             input logic [IP_W-1:0] qip);
        arp_item_t it;
        it            = rx_item(11'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), rand_mac(), $urandom, $urandom);
        it.opcode     = op;
        it.query_ip   = qip;
        return it;
    endfunction

    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(9) < 9)
            return ip_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Mostly well-formed packets and queries over a small address pool so that
    // learning, refresh, hits and the full table are all reached; the rest is
    // noise and near-miss headers.
    function automatic arp_item_t random_item();
        arp_item_t   it;
        int          roll;
        logic [15:0] oper;
        roll = $urandom_range(99);
        case ($urandom_range(3))
            0:       oper = OPER_REPLY;
            1:       oper = 16'($urandom);
            default: oper = OPER_REQUEST;
        endcase
        if (roll < 55)
            it = rx_item(11'($urandom_range(2047, MIN_ARP_LEN)), HTYPE_ETHERNET,
                         PTYPE_IPV4, oper, rand_mac(), pick_ip(),
                         $urandom_range(1) ? station_ip : pick_ip());
        else if (roll < 80)
            it = query_item($urandom_range(1) ? OP_LOOKUP : OP_RESOLVE, pick_ip());
        else if (roll < 90)
        begin
            // one header check broken at a time
            it = rx_item(11'($urandom_range(2047, MIN_ARP_LEN)), HTYPE_ETHERNET,
                         PTYPE_IPV4, oper, rand_mac(), pick_ip(), station_ip);
            case ($urandom_range(2))
                0:       it.packet_len = 11'($urandom_range(MIN_ARP_LEN - 1));
                1:       it.hw_type    = it.hw_type ^ 16'($urandom_range(65535, 1));
                default: it.proto_type = it.proto_type ^ 16'($urandom_range(65535, 1));
            endcase
        end
        else
        begin
            it        = query_item(2'($urandom_range(3)), $urandom);
            it.opcode = 2'($urandom_range(3));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Short, zero-length and bad type fields are rejected; both length limits
    // pass. The accepted packets also seed the table with address extremes.
    task automatic test_header_checks();
        push_item(rx_item(11'(MIN_ARP_LEN - 1), HTYPE_ETHERNET, PTYPE_IPV4, OPER_REQUEST,
                          48'h0000_1111_2222, 32'h0A00_0001, station_ip));
        push_item(rx_item(11'd0, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REQUEST,
                          48'h0000_1111_2222, 32'h0A00_0001, station_ip));
        push_item(rx_item(11'd2047, 16'h0000, PTYPE_IPV4, OPER_REQUEST,
                          48'h0000_1111_2222, 32'h0A00_0001, station_ip));
        push_item(rx_item(MIN_ARP_LEN, 16'hFFFF, PTYPE_IPV4, OPER_REQUEST,
                          48'h0000_1111_2222, 32'h0A00_0001, station_ip));
        push_item(rx_item(MIN_ARP_LEN, HTYPE_ETHERNET, 16'h0806, OPER_REQUEST,
                          48'h0000_1111_2222, 32'h0A00_0001, station_ip));
        push_item(rx_item(MIN_ARP_LEN, HTYPE_ETHERNET, 16'hFFFF, OPER_REQUEST,
                          48'h0000_1111_2222, 32'h0A00_0001, station_ip));
        push_item(rx_item(MIN_ARP_LEN, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REPLY,
                          48'h0, 32'h0, 32'h0));
        push_item(rx_item(11'd2047, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REQUEST,
                          48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, station_ip));
    endtask

    // A second packet from a known IP refreshes its MAC in place.
    task automatic test_learn_refresh();
        push_item(query_item(OP_LOOKUP, 32'h0));
        push_item(rx_item(11'd64, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REPLY,
                          48'h0123_4567_89AB, 32'h0, 32'h0A00_0002));
        push_item(query_item(OP_LOOKUP, 32'h0));
        push_item(query_item(OP_LOOKUP, 32'hFFFF_FFFF));
    endtask

    // Only a request aimed at our IP gets a reply.
    task automatic test_reply_rules();
        push_item(rx_item(11'd42, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REQUEST,
                          48'h02AA_BBCC_DDEE, 32'hC0A8_0010, station_ip ^ 32'h1));
        push_item(rx_item(11'd42, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REPLY,
                          48'h02AA_BBCC_DDEF, 32'hC0A8_0011, station_ip));
        push_item(rx_item(11'd42, HTYPE_ETHERNET, PTYPE_IPV4, 16'hFFFF,
                          48'h02AA_BBCC_DDF0, 32'hC0A8_0012, station_ip));
    endtask

    // Lookup and resolve misses, a resolve hit and the unused opcode.
    task automatic test_queries();
        arp_item_t it;
        push_item(query_item(OP_LOOKUP, 32'h0A00_0001));
        push_item(query_item(OP_RESOLVE, 32'h0A00_0001));
        push_item(query_item(OP_RESOLVE, 32'hFFFF_FFFF));
        it        = rx_item(11'd60, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REQUEST,
                            48'h0200_0000_0099, 32'h0A00_0003, station_ip);
        it.opcode = OP_UNUSED;
        it.query_ip = 32'hFFFF_FFFF;
        push_item(it);
    endtask

    // Random traffic, the sender idling before an item with probability pct in a
    // hundred; halfway through, the sender waits for every outstanding result.
    task automatic test_random_traffic(input int pct);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS / 2)
                drain_results();
            // stretches without idling even in the idle phases
            if ((n / 25) % 2 == 0)
                idle_gap(pct);
            push_item(random_item());
        end
    endtask

    // Fill any free slots, then a new pair is accepted but not stored, while
    // a known pair can still be refreshed.
    task automatic test_full_table();
        logic [IP_W-1:0] ip;
        while (!(&cache_valid))
        begin
            ip = $urandom;
            if (find_slot(ip) < 0)
                push_item(rx_item(11'd28, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REPLY,
                                  rand_mac(), ip, $urandom));
        end
        do
            ip = $urandom;
        while (find_slot(ip) >= 0);
        push_item(rx_item(11'd28, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REQUEST,
                          rand_mac(), ip, station_ip));
        push_item(query_item(OP_LOOKUP, ip));
        push_item(query_item(OP_RESOLVE, ip));
        push_item(rx_item(11'd28, HTYPE_ETHERNET, PTYPE_IPV4, OPER_REPLY,
                          rand_mac(), cache_ip[TABLE_ENTRIES_DEF-1], $urandom));
        push_item(query_item(OP_LOOKUP, cache_ip[TABLE_ENTRIES_DEF-1]));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // every input known from time zero; reset held low to begin with
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_RX;
        packet_len  = '0;
        hw_type     = '0;
        proto_type  = '0;
        operation   = '0;
        sender_mac  = '0;
        sender_ip   = '0;
        tgt_ip      = '0;
        query_ip    = '0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_OUR_MAC;
        cfg_data    = '0;
        cache_valid = '0;
        station_ip  = '0;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
        begin
            cache_ip[i]  = '0;
            cache_mac[i] = '0;
        end
        // pool with both address extremes
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_station(48'hFFFF_FFFF_FFFF, 32'hC0A8_0001);
        test_header_checks();
        test_learn_refresh();
        test_reply_rules();
        test_queries();

        set_station(48'h0, 32'h0);
        test_random_traffic(0);
        set_station(rand_mac(), 32'hFFFF_FFFF);
        test_random_traffic(74);
        set_station(rand_mac(), ip_pool[3]);
        test_random_traffic(32);

        test_full_table();

        // let any stray result show before the verdict
        drain_results();
        repeat (ITEM_CYCLES + 4) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_cell.sv
rtl/core/arpc_ctrl.sv
rtl/core/arp_cache_and_responder.sv
rtl/core/arpc_checker.sv
bench/tb.sv
